// ===== hdl/m6502eu_pkg.sv =====
package m6502eu_pkg;

    localparam logic [7:0] RstSp    = 8'hFD;
    localparam logic [7:0] RstFlags = 8'h24;
    localparam logic [7:0] FlB      = 8'h10;
    localparam logic [7:0] FlU      = 8'h20;
    localparam logic [7:0] FlBU     = 8'h30;

    localparam int FN = 7;
    localparam int FV = 6;
    localparam int FD = 3;
    localparam int FI = 2;
    localparam int FZ = 1;
    localparam int FC = 0;

    typedef struct packed {
        logic       we;
        logic [7:0] wv;
        logic       taken;
        logic [1:0] extra;
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] s;
        logic [7:0] f;
    } t_result;

    // {carry, overflow, sum}
    function automatic logic [9:0] adc8(logic [7:0] a, logic [7:0] m, logic c);
        logic [8:0] sum;
        logic       v;
        sum = {1'b0, a} + {1'b0, m} + {8'd0, c};
        v   = ~(a[7] ^ m[7]) & (a[7] ^ sum[7]);
        return {sum[8], v, sum[7:0]};
    endfunction

    // kind: 0 ASL, 1 ROL, 2 LSR, 3 ROR; returns {carry, result}
    function automatic logic [8:0] shf(logic [1:0] kind, logic [7:0] v, logic cin);
        logic [8:0] res;
        unique case (kind)
            2'd0: res = {v[7], v[6:0], 1'b0};
            2'd1: res = {v[7], v[6:0], cin};
            2'd2: res = {v[0], 1'b0, v[7:1]};
            default: res = {v[0], cin, v[7:1]};
        endcase
        return res;
    endfunction

    function automatic logic page_penalty(logic [7:0] op);
        logic p;
        unique case (op)
            8'h11, 8'h19, 8'h1D, 8'h31, 8'h39, 8'h3D,
            8'h51, 8'h59, 8'h5D, 8'h71, 8'h79, 8'h7D,
            8'hB1, 8'hB9, 8'hBD, 8'hD1, 8'hD9, 8'hDD,
            8'hF1, 8'hF9, 8'hFD, 8'hBC, 8'hBE, 8'hB3,
            8'hBF, 8'hBB, 8'h1C, 8'h3C, 8'h5C, 8'h7C,
            8'hDC, 8'hFC: p = 1'b1;
            default: p = 1'b0;
        endcase
        return p;
    endfunction

endpackage

// ===== hdl/mos6502_execute_unit_top.sv =====
// Channel | valid      | stall       | fields
// in      | i_in_valid | o_in_stall  | i_opcode i_operand i_address_high i_page_crossed
// out     | o_out_valid| i_out_stall | o_write_enable .. o_flags_value
// One instruction per cycle while o_in_stall is low; each result is registered.
// Registers A X Y S P update at the input beat; the result lands in an output
// register backed by one skid entry.
// o_in_stall rises only while the skid entry is occupied.
// Synchronous active-low reset: A X Y = 0, S = 0xFD, P = 0x24, both result slots empty.
module mos6502_execute_unit_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_opcode,
    input  logic [7:0] i_operand,
    input  logic [7:0] i_address_high,
    input  logic       i_page_crossed,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_write_enable,
    output logic [7:0] o_write_value,
    output logic       o_branch_taken,
    output logic [1:0] o_extra_cycles,
    output logic [7:0] o_acc_value,
    output logic [7:0] o_x_value,
    output logic [7:0] o_y_value,
    output logic [7:0] o_stack_value,
    output logic [7:0] o_flags_value
);

    logic [7:0] r_a, r_x, r_y, r_s, r_f;
    m6502eu_pkg::t_result r_out, r_skid, n_res;
    logic r_out_valid, r_skid_valid;
    logic in_acc, out_take;

    assign o_in_stall = r_skid_valid;
    assign in_acc     = i_in_valid & ~r_skid_valid;
    assign out_take   = r_out_valid & ~i_out_stall;

    always_comb begin
        logic [7:0] op, m, hp1, a, x, y, s, f, r, wv;
        logic       we, taken;
        logic [2:0] grp;
        logic [8:0] sh;
        logic [9:0] ad;
        logic [8:0] df;
        logic       cond;
        op = i_opcode;
        m = i_operand;
        hp1 = i_address_high + 8'd1;
        a = r_a; x = r_x; y = r_y; s = r_s; f = r_f;
        we = 1'b0; wv = 8'd0; taken = 1'b0;
        grp = op[7:5];
        r = 8'd0; sh = 9'd0; ad = 10'd0; df = 9'd0; cond = 1'b0;
        unique case (op)
            8'h00: begin
                we = 1'b1; wv = f | m6502eu_pkg::FlBU; s = s - 8'd3;
                f[m6502eu_pkg::FI] = 1'b1;
            end
            8'h20: s = s - 8'd2;
            8'h40: begin
                f = (m & ~m6502eu_pkg::FlB) | m6502eu_pkg::FlU; s = s + 8'd3;
            end
            8'h60: s = s + 8'd2;
            8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC: begin
                y = m; r = m;
            end
            8'hC0, 8'hC4, 8'hCC, 8'hE0, 8'hE4, 8'hEC: begin
                r = op[5] ? x : y;
                df = {1'b0, r} - {1'b0, m};
                f[m6502eu_pkg::FC] = ~df[8]; r = df[7:0];
            end
            8'h24, 8'h2C: begin
                f[m6502eu_pkg::FZ] = (m & a) == 8'd0;
                f[m6502eu_pkg::FN] = m[7]; f[m6502eu_pkg::FV] = m[6];
            end
            8'h84, 8'h8C, 8'h94: begin we = 1'b1; wv = y; end
            8'h9C: begin we = 1'b1; wv = y & hp1; end
            8'h08: begin we = 1'b1; wv = f | m6502eu_pkg::FlBU; s = s - 8'd1; end
            8'h28: begin f = (m & ~m6502eu_pkg::FlB) | m6502eu_pkg::FlU; s = s + 8'd1; end
            8'h48: begin we = 1'b1; wv = a; s = s - 8'd1; end
            8'h68: begin a = m; s = s + 8'd1; end
            8'h88: y = y - 8'd1;
            8'hC8: y = y + 8'd1;
            8'hCA: x = x - 8'd1;
            8'hE8: x = x + 8'd1;
            8'hA8: y = a;
            8'h98: a = y;
            8'hAA: x = a;
            8'h8A: a = x;
            8'h9A: s = x;
            8'hBA: x = s;
            8'hA2: x = m;
            8'h18: f[m6502eu_pkg::FC] = 1'b0;
            8'h38: f[m6502eu_pkg::FC] = 1'b1;
            8'h58: f[m6502eu_pkg::FI] = 1'b0;
            8'h78: f[m6502eu_pkg::FI] = 1'b1;
            8'hB8: f[m6502eu_pkg::FV] = 1'b0;
            8'hD8: f[m6502eu_pkg::FD] = 1'b0;
            8'hF8: f[m6502eu_pkg::FD] = 1'b1;
            8'h9E: begin we = 1'b1; wv = x & hp1; end
            8'h89: ;
            8'h0B, 8'h2B: begin a = a & m; f[m6502eu_pkg::FC] = a[7]; end
            8'h4B: begin
                r = a & m; f[m6502eu_pkg::FC] = r[0]; a = {1'b0, r[7:1]};
            end
            8'h6B: begin
                r = a & m; a = {f[m6502eu_pkg::FC], r[7:1]};
                f[m6502eu_pkg::FC] = a[6]; f[m6502eu_pkg::FV] = a[6] ^ a[5];
            end
            8'h8B: a = a & x & m;
            8'hAB: begin a = a & m; x = a; end
            8'hCB: begin
                df = {1'b0, a & x} - {1'b0, m};
                f[m6502eu_pkg::FC] = ~df[8]; x = df[7:0];
            end
            8'hEB: begin
                ad = m6502eu_pkg::adc8(a, ~m, f[m6502eu_pkg::FC]);
                f[m6502eu_pkg::FC] = ad[9]; f[m6502eu_pkg::FV] = ad[8]; a = ad[7:0];
            end
            8'h9B: begin s = a & x; we = 1'b1; wv = s & hp1; end
            8'hBB: begin r = m & s; a = r; x = r; s = r; end
            8'h93, 8'h9F: begin we = 1'b1; wv = a & x & hp1; end
            default: begin
                if (op[1:0] == 2'b01 || op[1:0] == 2'b11) begin
                    r = m;
                    if (op[1]) begin
                        unique case (grp)
                            3'd0, 3'd1, 3'd2, 3'd3: begin
                                sh = m6502eu_pkg::shf(grp[1:0], m, f[m6502eu_pkg::FC]);
                                f[m6502eu_pkg::FC] = sh[8]; r = sh[7:0];
                                we = 1'b1; wv = r;
                            end
                            3'd6: begin r = m - 8'd1; we = 1'b1; wv = r; end
                            3'd7: begin r = m + 8'd1; we = 1'b1; wv = r; end
                            default: ;
                        endcase
                    end
                    unique case (grp)
                        3'd0: a = a | r;
                        3'd1: a = a & r;
                        3'd2: a = a ^ r;
                        3'd3, 3'd7: begin
                            ad = m6502eu_pkg::adc8(a, grp[2] ? ~r : r, f[m6502eu_pkg::FC]);
                            f[m6502eu_pkg::FC] = ad[9]; f[m6502eu_pkg::FV] = ad[8];
                            a = ad[7:0];
                        end
                        3'd4: begin we = 1'b1; wv = op[1] ? (a & x) : a; end
                        3'd5: begin a = m; if (op[1]) x = m; end
                        default: begin
                            df = {1'b0, a} - {1'b0, r};
                            f[m6502eu_pkg::FC] = ~df[8]; r = df[7:0];
                        end
                    endcase
                end else if (op[1:0] == 2'b10) begin
                    if (op[2:0] == 3'd6) begin
                        unique case (grp)
                            3'd0, 3'd1, 3'd2, 3'd3: begin
                                sh = m6502eu_pkg::shf(grp[1:0], m, f[m6502eu_pkg::FC]);
                                f[m6502eu_pkg::FC] = sh[8]; r = sh[7:0];
                                we = 1'b1; wv = r;
                            end
                            3'd4: begin we = 1'b1; wv = x; end
                            3'd5: begin x = m; r = m; end
                            3'd6: begin r = m - 8'd1; we = 1'b1; wv = r; end
                            default: begin r = m + 8'd1; we = 1'b1; wv = r; end
                        endcase
                    end else if (op[4:0] == 5'h0A && !grp[2]) begin
                        sh = m6502eu_pkg::shf(grp[1:0], a, f[m6502eu_pkg::FC]);
                        f[m6502eu_pkg::FC] = sh[8]; a = sh[7:0];
                    end
                end else if (op[4:0] == 5'h10) begin
                    unique case (op[7:6])
                        2'd0: cond = f[m6502eu_pkg::FN];
                        2'd1: cond = f[m6502eu_pkg::FV];
                        2'd2: cond = f[m6502eu_pkg::FC];
                        default: cond = f[m6502eu_pkg::FZ];
                    endcase
                    taken = (cond == op[5]);
                end
            end
        endcase

        // N/Z source per opcode
        priority case (1'b1)
            (op == 8'hA0 || op == 8'hA4 || op == 8'hAC || op == 8'hB4 || op == 8'hBC ||
             op == 8'hC0 || op == 8'hC4 || op == 8'hCC || op == 8'hE0 || op == 8'hE4 ||
             op == 8'hEC || op == 8'hBB): begin
                f[m6502eu_pkg::FN] = r[7]; f[m6502eu_pkg::FZ] = r == 8'd0;
            end
            (op == 8'h88 || op == 8'hC8): begin
                f[m6502eu_pkg::FN] = y[7]; f[m6502eu_pkg::FZ] = y == 8'd0;
            end
            (op == 8'hCA || op == 8'hE8 || op == 8'hAA || op == 8'hBA || op == 8'hA2 ||
             op == 8'hCB): begin
                f[m6502eu_pkg::FN] = x[7]; f[m6502eu_pkg::FZ] = x == 8'd0;
            end
            (op == 8'hA8): begin
                f[m6502eu_pkg::FN] = y[7]; f[m6502eu_pkg::FZ] = y == 8'd0;
            end
            (op == 8'h68 || op == 8'h98 || op == 8'h8A || op == 8'h0B || op == 8'h2B ||
             op == 8'h4B || op == 8'h6B || op == 8'h8B || op == 8'hAB || op == 8'hEB): begin
                f[m6502eu_pkg::FN] = a[7]; f[m6502eu_pkg::FZ] = a == 8'd0;
            end
            (op == 8'h00 || op == 8'h20 || op == 8'h40 || op == 8'h60 || op == 8'h24 ||
             op == 8'h2C || op == 8'h84 || op == 8'h8C || op == 8'h94 || op == 8'h9C ||
             op == 8'h08 || op == 8'h28 || op == 8'h48 || op == 8'h9A || op == 8'h18 ||
             op == 8'h38 || op == 8'h58 || op == 8'h78 || op == 8'hB8 || op == 8'hD8 ||
             op == 8'hF8 || op == 8'h9E || op == 8'h89 || op == 8'h9B || op == 8'h93 ||
             op == 8'h9F): ;
            (op[0] && grp == 3'd6): begin
                f[m6502eu_pkg::FN] = r[7]; f[m6502eu_pkg::FZ] = r == 8'd0;
            end
            (op[0] && grp != 3'd4): begin
                f[m6502eu_pkg::FN] = a[7]; f[m6502eu_pkg::FZ] = a == 8'd0;
            end
            (op[1:0] == 2'b10 && op[2:0] == 3'd6 && grp != 3'd4): begin
                f[m6502eu_pkg::FN] = r[7]; f[m6502eu_pkg::FZ] = r == 8'd0;
            end
            (op[1:0] == 2'b10 && op[4:0] == 5'h0A && !grp[2]): begin
                f[m6502eu_pkg::FN] = a[7]; f[m6502eu_pkg::FZ] = a == 8'd0;
            end
            default: ;
        endcase

        n_res.we    = we;
        n_res.wv    = wv;
        n_res.taken = taken;
        if (taken) begin
            n_res.extra = 2'd1 + {1'b0, i_page_crossed};
        end else if (m6502eu_pkg::page_penalty(op)) begin
            n_res.extra = {1'b0, i_page_crossed};
        end else begin
            n_res.extra = 2'd0;
        end
        n_res.a = a;
        n_res.x = x;
        n_res.y = y;
        n_res.s = s;
        n_res.f = f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= 8'd0;
            r_x <= 8'd0;
            r_y <= 8'd0;
            r_s <= m6502eu_pkg::RstSp;
            r_f <= m6502eu_pkg::RstFlags;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_a <= n_res.a;
                r_x <= n_res.x;
                r_y <= n_res.y;
                r_s <= n_res.s;
                r_f <= n_res.f;
                if (r_out_valid && i_out_stall) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (out_take) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (r_out_valid && i_out_stall) begin
                r_skid <= n_res;
            end else begin
                r_out <= n_res;
            end
        end else if (out_take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_write_enable = r_out.we;
    assign o_write_value  = r_out.wv;
    assign o_branch_taken = r_out.taken;
    assign o_extra_cycles = r_out.extra;
    assign o_acc_value    = r_out.a;
    assign o_x_value      = r_out.x;
    assign o_y_value      = r_out.y;
    assign o_stack_value  = r_out.s;
    assign o_flags_value  = r_out.f;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid) else $error("skid holds a beat with output empty");
    a_u_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f & m6502eu_pkg::FlBU) == m6502eu_pkg::FlU)
        else $error("status U/B bits corrupted");
    a_wv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_write_enable) |-> (o_write_value == 8'd0))
        else $error("write value without write enable");
    a_extra_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_branch_taken) |-> (o_extra_cycles != 2'd2))
        else $error("extra cycles too large without branch");

endmodule
